/* sv/fat12_cluster_chain_walker_macros.svh */
// Assertion macros used by the top level of the cluster chain walker.
`ifndef FAT12_CLUSTER_CHAIN_WALKER_MACROS_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define F12CCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define F12CCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/f12ccw_pkg.sv */
// Types and constants shared by the cluster chain walker modules.
`timescale 1ns / 1ps

package f12ccw_pkg;

  // Allocation table storage, split into an even-byte bank and an odd-byte bank.
  localparam int TABLE_BYTES = 8192;
  localparam int TABLE_AW    = $clog2(TABLE_BYTES);
  localparam int BANK_AW     = TABLE_AW - 1;
  localparam int BANK_DEPTH  = TABLE_BYTES / 2;

  // Field widths.
  localparam int OP_W       = 2;
  localparam int TBL_ADDR_W = 13;
  localparam int BYTE_W     = 8;
  localparam int CLUSTER_W  = 12;
  localparam int LBA_W      = 32;
  localparam int SPC_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int PROD_W     = LBA_W + SPC_W;

  // Byte offsets into the table, with headroom for the range compare.
  localparam int OFF_W = TBL_ADDR_W + 1;
  localparam logic [OFF_W-1:0] TABLE_END = OFF_W'(TABLE_BYTES);

  localparam logic [CLUSTER_W-1:0] END_MARK   = 12'hFF8;
  localparam int                   ODD_SHIFT  = 4;
  localparam logic [LBA_W-1:0]     FIRST_DATA = 32'd2;

  localparam logic [LBA_W-1:0] DATA_START_RESET = 32'd33;
  localparam logic [SPC_W-1:0] SPC_RESET        = 8'd1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTORS    = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_START   = 2'd1,
    OP_ADVANCE = 2'd2
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_en;      // write the table byte of the accepted load
    logic rd_en;      // read both bytes of the current cluster's entry
    logic set_start;  // take the start cluster
    logic decode_en;  // decode the table word into the next cluster
    logic mult_en;    // register the sector offset product
    logic sum_en;     // register the result beat
    logic blank;      // the result beat is all zero
  } cmd_t;

endpackage

/* sv/f12ccw_ctrl.sv */
// Controller state machine of the cluster chain walker.
`timescale 1ns / 1ps

module f12ccw_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic [f12ccw_pkg::OP_W-1:0] operation_i,
  output logic                        busy,
  output logic                        strobe_o,
  output f12ccw_pkg::cmd_t            cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECODE = 4'b0010,
    S_MULT   = 4'b0100,
    S_SUM    = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   blank_q, blank_d;
  logic   strobe_q, strobe_d;
  logic   accept;

  assign accept = start && (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    blank_d  = blank_q;
    strobe_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (f12ccw_pkg::op_e'(operation_i))
            f12ccw_pkg::OP_START: begin
              state_d = S_MULT;
              blank_d = 1'b0;
            end
            f12ccw_pkg::OP_ADVANCE: begin
              state_d = S_DECODE;
              blank_d = 1'b0;
            end
            default: begin
              state_d = S_SUM;
              blank_d = 1'b1;
            end
          endcase
        end
      end
      S_DECODE: state_d = S_MULT;
      S_MULT:   state_d = S_SUM;
      S_SUM: begin
        state_d  = S_IDLE;
        strobe_d = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      blank_q  <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      blank_q  <= blank_d;
      strobe_q <= strobe_d;
    end
  end

  always_comb begin
    cmd_o.wr_en     = accept && (operation_i == f12ccw_pkg::OP_LOAD);
    cmd_o.rd_en     = accept && (operation_i == f12ccw_pkg::OP_ADVANCE);
    cmd_o.set_start = accept && (operation_i == f12ccw_pkg::OP_START);
    cmd_o.decode_en = (state_q == S_DECODE);
    cmd_o.mult_en   = (state_q == S_MULT);
    cmd_o.sum_en    = (state_q == S_SUM);
    cmd_o.blank     = blank_q;
  end

  assign busy     = (state_q != S_IDLE);
  assign strobe_o = strobe_q;

endmodule

/* sv/f12ccw_datapath.sv */
// Datapath of the cluster chain walker: table banks, decode, sector arithmetic.
`timescale 1ns / 1ps

module f12ccw_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  f12ccw_pkg::cmd_t                  cmd_i,
  input  logic                              cfg_we_i,
  input  logic [f12ccw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [f12ccw_pkg::LBA_W-1:0]      cfg_wdata_i,
  input  logic [f12ccw_pkg::TBL_ADDR_W-1:0] table_address_i,
  input  logic [f12ccw_pkg::BYTE_W-1:0]     table_byte_i,
  input  logic [f12ccw_pkg::CLUSTER_W-1:0]  start_cluster_i,
  output logic [f12ccw_pkg::CLUSTER_W-1:0]  cluster_o,
  output logic [f12ccw_pkg::LBA_W-1:0]      lba_o,
  output logic                              end_of_chain_o
);

  // Configuration registers.
  logic [f12ccw_pkg::LBA_W-1:0] data_start_q;
  logic [f12ccw_pkg::SPC_W-1:0] spc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_start_q <= f12ccw_pkg::DATA_START_RESET;
      spc_q        <= f12ccw_pkg::SPC_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        f12ccw_pkg::CFG_DATA_START: data_start_q <= cfg_wdata_i;
        f12ccw_pkg::CFG_SECTORS:    spc_q        <= cfg_wdata_i[f12ccw_pkg::SPC_W-1:0];
        default: ;
      endcase
    end
  end

  // Table banks: even byte offsets in one, odd in the other, so that both
  // bytes of an entry come out in the same cycle.
  logic [f12ccw_pkg::BYTE_W-1:0] even_mem [f12ccw_pkg::BANK_DEPTH];
  logic [f12ccw_pkg::BYTE_W-1:0] odd_mem  [f12ccw_pkg::BANK_DEPTH];

  logic                           wr_ok;
  logic [f12ccw_pkg::BANK_AW-1:0] wr_idx;

  assign wr_ok  = cmd_i.wr_en &&
                  ({1'b0, table_address_i} < f12ccw_pkg::TABLE_END);
  assign wr_idx = table_address_i[f12ccw_pkg::TABLE_AW-1:1];

  logic [f12ccw_pkg::CLUSTER_W-1:0] cluster_q;
  logic [f12ccw_pkg::OFF_W-1:0]     off;
  logic [f12ccw_pkg::OFF_W-1:0]     off_p1;
  logic [f12ccw_pkg::BANK_AW-1:0]   even_idx;
  logic [f12ccw_pkg::BANK_AW-1:0]   odd_idx;

  assign off      = {2'b00, cluster_q} + {3'b000, cluster_q[f12ccw_pkg::CLUSTER_W-1:1]};
  assign off_p1   = off + f12ccw_pkg::OFF_W'(1);
  assign even_idx = off_p1[f12ccw_pkg::BANK_AW:1];
  assign odd_idx  = off[f12ccw_pkg::BANK_AW:1];

  logic [f12ccw_pkg::BYTE_W-1:0] even_rd_q;
  logic [f12ccw_pkg::BYTE_W-1:0] odd_rd_q;
  logic                          off_odd_q;
  logic                          clus_odd_q;
  logic                          lo_ok_q;
  logic                          hi_ok_q;

  always_ff @(posedge clk_i) begin
    if (wr_ok && !table_address_i[0]) begin
      even_mem[wr_idx] <= table_byte_i;
    end
    if (cmd_i.rd_en) begin
      even_rd_q <= even_mem[even_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok && table_address_i[0]) begin
      odd_mem[wr_idx] <= table_byte_i;
    end
    if (cmd_i.rd_en) begin
      odd_rd_q <= odd_mem[odd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      off_odd_q  <= off[0];
      clus_odd_q <= cluster_q[0];
      lo_ok_q    <= (off < f12ccw_pkg::TABLE_END);
      hi_ok_q    <= (off_p1 < f12ccw_pkg::TABLE_END);
    end
  end

  // Decode of the 12-bit entry; bytes past the table read as zero.
  logic [f12ccw_pkg::BYTE_W-1:0]    lo_byte;
  logic [f12ccw_pkg::BYTE_W-1:0]    hi_byte;
  logic [2*f12ccw_pkg::BYTE_W-1:0]  word;
  logic [f12ccw_pkg::CLUSTER_W-1:0] next_cluster;

  always_comb begin
    lo_byte = off_odd_q ? odd_rd_q : even_rd_q;
    hi_byte = off_odd_q ? even_rd_q : odd_rd_q;
    if (!lo_ok_q) lo_byte = '0;
    if (!hi_ok_q) hi_byte = '0;
    word = {hi_byte, lo_byte};
    if (clus_odd_q) begin
      next_cluster = word[f12ccw_pkg::ODD_SHIFT +: f12ccw_pkg::CLUSTER_W];
    end else begin
      next_cluster = word[f12ccw_pkg::CLUSTER_W-1:0];
    end
  end

  logic end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_q <= '0;
      end_q     <= 1'b0;
    end else if (cmd_i.set_start) begin
      cluster_q <= start_cluster_i;
      end_q     <= 1'b0;
    end else if (cmd_i.decode_en) begin
      cluster_q <= next_cluster;
      end_q     <= (next_cluster >= f12ccw_pkg::END_MARK);
    end
  end

  // Sector offset (cluster - 2) * sectors per cluster, modulo 2^32.
  logic [f12ccw_pkg::LBA_W-1:0]  rel;
  logic [f12ccw_pkg::PROD_W-1:0] prod_full;
  logic [f12ccw_pkg::LBA_W-1:0]  prod_q;

  assign rel       = {{(f12ccw_pkg::LBA_W-f12ccw_pkg::CLUSTER_W){1'b0}}, cluster_q}
                     - f12ccw_pkg::FIRST_DATA;
  assign prod_full = {{f12ccw_pkg::SPC_W{1'b0}}, rel} *
                     {{f12ccw_pkg::LBA_W{1'b0}}, spc_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mult_en) begin
      prod_q <= prod_full[f12ccw_pkg::LBA_W-1:0];
    end
  end

  // Result register.
  logic [f12ccw_pkg::CLUSTER_W-1:0] res_cluster_q;
  logic [f12ccw_pkg::LBA_W-1:0]     res_lba_q;
  logic                             res_end_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      if (cmd_i.blank) begin
        res_cluster_q <= '0;
        res_lba_q     <= '0;
        res_end_q     <= 1'b0;
      end else begin
        res_cluster_q <= cluster_q;
        res_lba_q     <= end_q ? '0 : (data_start_q + prod_q);
        res_end_q     <= end_q;
      end
    end
  end

  assign cluster_o      = res_cluster_q;
  assign lba_o          = res_lba_q;
  assign end_of_chain_o = res_end_q;

endmodule

/* sv/fat12_cluster_chain_walker.sv */
// Top level of the FAT12 cluster chain walker.
`timescale 1ns / 1ps
`include "fat12_cluster_chain_walker_macros.svh"

// The walker keeps a FAT12 allocation table of 8192 bytes and follows cluster
// chains through it. An item is accepted at a rising edge with start high and
// busy low. A load writes one table byte, a start sets the current cluster,
// and an advance reads the 12-bit entry of the current cluster and moves to
// the cluster it names; each item answers with exactly one result beat on
// cluster_o, lba_o and end_of_chain_o, marked by strobe_o for one cycle.
// The receiver cannot stall, so every beat must be taken in the cycle it is
// shown. A load goes straight to its beat, a start first registers the sector
// multiply and then the add, and an advance reads both entry bytes in the
// same cycle from an even and an odd table bank, decodes them, then registers
// the 32 x 8 sector multiply and then the add of the data start sector. busy
// falls in the cycle the beat is shown, so the next item may be accepted
// while strobe_o is high. Configuration writes (index 0 data start sector,
// index 1 sectors per cluster) take effect at once and should be made while
// the block is idle. Table bytes are not cleared by reset; an advance must
// only read entries that were loaded. An advance that decodes 0xFF8 or above
// flags end of chain with lba_o zero and keeps that value as the current
// cluster. Loads and unused operation codes answer with an all-zero beat.

module fat12_cluster_chain_walker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [f12ccw_pkg::OP_W-1:0]       operation_i,
  input  logic [f12ccw_pkg::TBL_ADDR_W-1:0] table_address_i,
  input  logic [f12ccw_pkg::BYTE_W-1:0]     table_byte_i,
  input  logic [f12ccw_pkg::CLUSTER_W-1:0]  start_cluster_i,
  output logic                              strobe_o,
  output logic [f12ccw_pkg::CLUSTER_W-1:0]  cluster_o,
  output logic [f12ccw_pkg::LBA_W-1:0]      lba_o,
  output logic                              end_of_chain_o,
  input  logic                              cfg_we_i,
  input  logic [f12ccw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [f12ccw_pkg::LBA_W-1:0]      cfg_wdata_i
);

  f12ccw_pkg::cmd_t cmd;

  // Sequencing of each item: accept, read and decode (advance only), multiply (advance and start), sum.
  f12ccw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (operation_i),
    .busy        (busy),
    .strobe_o    (strobe_o),
    .cmd_o       (cmd)
  );

  // Table storage, current cluster, configuration and sector arithmetic.
  f12ccw_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .table_address_i (table_address_i),
    .table_byte_i    (table_byte_i),
    .start_cluster_i (start_cluster_i),
    .cluster_o       (cluster_o),
    .lba_o           (lba_o),
    .end_of_chain_o  (end_of_chain_o)
  );

  // A beat only ever closes a busy period.
  `F12CCW_ASSERT_NOW(a_beat_after_busy, strobe_o, $past(busy), "result beat without a preceding busy cycle")

  // Every accepted item makes the block busy in the next cycle.
  `F12CCW_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy && !strobe_o, "accepted item did not start work")

  // End of chain carries a terminal cluster value and a zero sector.
  `F12CCW_ASSERT_NOW(a_end_beat_shape, strobe_o && end_of_chain_o, (lba_o == '0) && (cluster_o >= f12ccw_pkg::END_MARK), "end of chain beat with bad cluster or sector")

  // A load answers with an all-zero beat once its sum state has run.
  `F12CCW_ASSERT_NEXT(a_load_beat_zero, start && !busy && (operation_i == f12ccw_pkg::OP_LOAD), ##1 (strobe_o && (cluster_o == '0) && (lba_o == '0) && !end_of_chain_o), "load did not answer with a zero beat")

endmodule

/* tb/tb_fat12_cluster_chain_walker.sv */
// Self-checking testbench for the FAT12 cluster chain walker.
`timescale 1ns / 1ps

// The testbench plans a stream of commands (table loads, chain starts and
// advances) into a queue. A clocked driver hands them to the walker one at a
// time. At every accepted command it updates a private copy of the table and
// the current cluster, and it queues the result beat that the command must
// produce. A clocked monitor compares every strobed beat, field by field,
// against the oldest queued beat.
//
// The planner keeps its own view of which table bytes have been loaded. It
// never issues an advance whose entry bytes were not written first. Most of
// the random stimulus is well-formed chain walks: start somewhere, link the
// entry of the current cluster to a chosen next cluster with two byte loads,
// then advance. The rest is stray loads, stray starts, stray advances on
// loaded entries and the reserved operation code.

module tb_fat12_cluster_chain_walker;
  import f12ccw_pkg::*;

  // Operation code 3 is not defined by the block; it must answer with a zero beat.
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int          PHASE_ITEMS   = 300;
  localparam int          SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [TBL_ADDR_W-1:0] addr;
    logic [BYTE_W-1:0]     byt;
    logic [CLUSTER_W-1:0]  clus;
  } walk_cmd_t;

  typedef struct packed {
    logic [CLUSTER_W-1:0] cluster;
    logic [LBA_W-1:0]     lba;
    logic                 eoc;
  } walk_beat_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  start           = 1'b0;
  logic                  busy;
  logic [OP_W-1:0]       operation_i     = '0;
  logic [TBL_ADDR_W-1:0] table_address_i = '0;
  logic [BYTE_W-1:0]     table_byte_i    = '0;
  logic [CLUSTER_W-1:0]  start_cluster_i = '0;
  logic                  strobe_o;
  logic [CLUSTER_W-1:0]  cluster_o;
  logic [LBA_W-1:0]      lba_o;
  logic                  end_of_chain_o;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [LBA_W-1:0]      cfg_wdata_i     = '0;

  fat12_cluster_chain_walker dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .table_address_i (table_address_i),
    .table_byte_i    (table_byte_i),
    .start_cluster_i (start_cluster_i),
    .strobe_o        (strobe_o),
    .cluster_o       (cluster_o),
    .lba_o           (lba_o),
    .end_of_chain_o  (end_of_chain_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // Commands waiting for the driver, and beats waiting for the monitor.
  walk_cmd_t  cmd_queue  [$];
  walk_beat_t beat_queue [$];

  // Predicted walker state, advanced only when the block accepts a command.
  logic [BYTE_W-1:0]    fat_tbl [TABLE_BYTES];
  logic [CLUSTER_W-1:0] cur_cluster = '0;
  logic [LBA_W-1:0]     data_start  = DATA_START_RESET;
  logic [SPC_W-1:0]     spc         = SPC_RESET;

  // Planner view of the table, used only to build legal command sequences.
  logic [BYTE_W-1:0]    plan_tbl [TABLE_BYTES];
  bit                   plan_wr  [TABLE_BYTES];
  logic [CLUSTER_W-1:0] plan_cl = '0;
  int                   planned = 0;

  int unsigned idle_pct   = 36;
  bit          drain_hold = 1'b0;
  int          fail_count = 0;
  int unsigned cycle_count = 0;
  walk_cmd_t   drv_cmd;
  walk_beat_t  exp_beat;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Byte offset of a cluster's 12-bit entry: cluster plus half the cluster.
  function automatic logic [TBL_ADDR_W-1:0] entry_off(input logic [CLUSTER_W-1:0] c);
    return {1'b0, c} + {2'b00, c[CLUSTER_W-1:1]};
  endfunction

  // Decode a little-endian entry word: an odd cluster owns the upper 12 bits.
  function automatic logic [CLUSTER_W-1:0] fat_entry(input logic [CLUSTER_W-1:0] c,
                                                      input logic [BYTE_W-1:0] lo,
                                                      input logic [BYTE_W-1:0] hi);
    logic [15:0] word;
    word = {hi, lo};
    if (c[0]) begin
      return word[15:4];
    end
    return word[11:0];
  endfunction

  // First sector of a cluster. Clusters 0 and 1 wrap below zero before the
  // multiply, and everything is taken modulo 2^32.
  function automatic logic [LBA_W-1:0] sector_lba(input logic [CLUSTER_W-1:0] c);
    logic [LBA_W-1:0] rel;
    logic [LBA_W-1:0] prod;
    rel  = {{(LBA_W-CLUSTER_W){1'b0}}, c} - FIRST_DATA;
    prod = rel * {{(LBA_W-SPC_W){1'b0}}, spc};
    return data_start + prod;
  endfunction

  // Applies one accepted command to the predicted state and returns its beat.
  function automatic walk_beat_t walk_predict(input walk_cmd_t cmd);
    walk_beat_t           b;
    logic [TBL_ADDR_W-1:0] off;
    logic [CLUSTER_W-1:0]  nxt;
    b = '0;
    case (cmd.op)
      OP_LOAD: begin
        fat_tbl[cmd.addr] = cmd.byt;
      end
      OP_START: begin
        // A start never flags end of chain, whatever the cluster value.
        cur_cluster = cmd.clus;
        b.cluster   = cmd.clus;
        b.lba       = sector_lba(cmd.clus);
      end
      OP_ADVANCE: begin
        off         = entry_off(cur_cluster);
        nxt         = fat_entry(cur_cluster, fat_tbl[off], fat_tbl[off + 1'b1]);
        cur_cluster = nxt;
        b.cluster   = nxt;
        if (nxt >= END_MARK) begin
          b.eoc = 1'b1;
        end else begin
          b.lba = sector_lba(nxt);
        end
      end
      default: begin
      end
    endcase
    return b;
  endfunction

  function automatic bit entry_ready(input logic [CLUSTER_W-1:0] c);
    logic [TBL_ADDR_W-1:0] off;
    off = entry_off(c);
    return plan_wr[off] && plan_wr[off + 1'b1];
  endfunction

  // Mostly ordinary data clusters, with end markers and the two clusters
  // below the data area mixed in.
  function automatic logic [CLUSTER_W-1:0] pick_next();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      return CLUSTER_W'($urandom_range(2, 12'hFF7));
    end
    if (r < 88) begin
      return CLUSTER_W'($urandom_range(12'hFF8, 12'hFFF));
    end
    if (r < 94) begin
      return CLUSTER_W'($urandom_range(0, 1));
    end
    return CLUSTER_W'($urandom);
  endfunction

  // Queues one command and tracks what the table and current cluster will be.
  task automatic plan_push(input logic [OP_W-1:0] op, input logic [TBL_ADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] byt, input logic [CLUSTER_W-1:0] clus);
    logic [TBL_ADDR_W-1:0] off;
    cmd_queue.push_back({op, addr, byt, clus});
    planned++;
    case (op)
      OP_LOAD: begin
        plan_tbl[addr] = byt;
        plan_wr[addr]  = 1'b1;
      end
      OP_START: begin
        plan_cl = clus;
      end
      OP_ADVANCE: begin
        off     = entry_off(plan_cl);
        plan_cl = fat_entry(plan_cl, plan_tbl[off], plan_tbl[off + 1'b1]);
      end
      default: begin
      end
    endcase
  endtask

  // Writes the entry of cluster c so that it names nxt. The byte shared with
  // the neighboring entry keeps its other nibble; if that byte was never
  // loaded, the nibble gets random content.
  task automatic plan_link(input logic [CLUSTER_W-1:0] c, input logic [CLUSTER_W-1:0] nxt);
    logic [TBL_ADDR_W-1:0] off;
    logic [BYTE_W-1:0]     lo;
    logic [BYTE_W-1:0]     hi;
    off = entry_off(c);
    lo  = plan_wr[off] ? plan_tbl[off] : BYTE_W'($urandom);
    hi  = plan_wr[off + 1'b1] ? plan_tbl[off + 1'b1] : BYTE_W'($urandom);
    if (c[0]) begin
      lo = {nxt[3:0], lo[3:0]};
      hi = nxt[11:4];
    end else begin
      lo = nxt[7:0];
      hi = {hi[7:4], nxt[11:8]};
    end
    if ($urandom_range(0, 1) == 0) begin
      plan_push(OP_LOAD, off, lo, CLUSTER_W'($urandom));
      plan_push(OP_LOAD, off + 1'b1, hi, CLUSTER_W'($urandom));
    end else begin
      plan_push(OP_LOAD, off + 1'b1, hi, CLUSTER_W'($urandom));
      plan_push(OP_LOAD, off, lo, CLUSTER_W'($urandom));
    end
  endtask

  task automatic plan_random(input int n);
    int          stop_at;
    int unsigned r;
    int unsigned steps;
    stop_at = planned + n;
    while (planned < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        // A chain walk: sometimes from a fresh start, otherwise from wherever
        // the previous walk stopped, end markers included.
        if ($urandom_range(0, 3) == 0) begin
          plan_push(OP_START, TBL_ADDR_W'($urandom), BYTE_W'($urandom), CLUSTER_W'($urandom));
        end
        steps = $urandom_range(1, 6);
        repeat (steps) begin
          if (!entry_ready(plan_cl) || $urandom_range(0, 2) == 0) begin
            plan_link(plan_cl, pick_next());
          end
          plan_push(OP_ADVANCE, TBL_ADDR_W'($urandom), BYTE_W'($urandom),
                    CLUSTER_W'($urandom));
        end
      end else if (r < 85) begin
        plan_push(OP_LOAD, TBL_ADDR_W'($urandom), BYTE_W'($urandom), CLUSTER_W'($urandom));
      end else if (r < 93) begin
        plan_push(OP_START, TBL_ADDR_W'($urandom), BYTE_W'($urandom), CLUSTER_W'($urandom));
      end else if (r < 97 && entry_ready(plan_cl)) begin
        plan_push(OP_ADVANCE, TBL_ADDR_W'($urandom), BYTE_W'($urandom), CLUSTER_W'($urandom));
      end else begin
        plan_push(OP_RESERVED, TBL_ADDR_W'($urandom), BYTE_W'($urandom),
                  CLUSTER_W'($urandom));
      end
    end
  endtask

  // Waits until every planned command was accepted and every beat was seen.
  task automatic wait_idle();
    while (cmd_queue.size() != 0 || start || beat_queue.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LBA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_DATA_START) begin
      data_start = value;
    end else begin
      spc = value[SPC_W-1:0];
    end
  endtask

  // Driver. A command is taken at an edge where start is high and busy is
  // low; only then is the next one chosen, so each command is held until it
  // is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        beat_queue.push_back(walk_predict({operation_i, table_address_i, table_byte_i,
                                           start_cluster_i}));
      end
      if (!start || !busy) begin
        // A drain hold keeps the sender quiet until every beat is back.
        if (drain_hold && beat_queue.size() == 0) begin
          drain_hold = 1'b0;
        end
        if (cmd_queue.size() != 0 && !drain_hold && $urandom_range(0, 99) >= idle_pct) begin
          drv_cmd = cmd_queue.pop_front();
          start           <= 1'b1;
          operation_i     <= drv_cmd.op;
          table_address_i <= drv_cmd.addr;
          table_byte_i    <= drv_cmd.byt;
          start_cluster_i <= drv_cmd.clus;
          if ($urandom_range(0, 149) == 0) begin
            drain_hold = 1'b1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every strobed beat must match the oldest predicted beat.
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      if (beat_queue.size() == 0) begin
        $error("unexpected beat: cluster %h lba %h end_of_chain %b",
               cluster_o, lba_o, end_of_chain_o);
        fail_count++;
      end else begin
        exp_beat = beat_queue.pop_front();
        if (cluster_o !== exp_beat.cluster) begin
          $error("cluster: expected %h, actual %h", exp_beat.cluster, cluster_o);
          fail_count++;
        end
        if (lba_o !== exp_beat.lba) begin
          $error("lba: expected %h, actual %h", exp_beat.lba, lba_o);
          fail_count++;
        end
        if (end_of_chain_o !== exp_beat.eoc) begin
          $error("end_of_chain: expected %b, actual %b", exp_beat.eoc, end_of_chain_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog against a hung handshake or a beat that never arrives.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, at the reset configuration. Extreme loads and the
    // reserved code first, then starts at the low and high ends (an end
    // marker on a start is not flagged), then a hand-built chain: even
    // cluster, odd cluster, last ordinary cluster, an end marker, an advance
    // out of that end marker to a cluster below two, and the highest marker.
    plan_push(OP_LOAD, '0, 8'h00, '0);
    plan_push(OP_LOAD, '1, 8'hFF, '1);
    plan_push(OP_RESERVED, '1, 8'hFF, '1);
    plan_push(OP_START, '0, '0, 12'h000);
    plan_push(OP_START, '1, '1, 12'hFF8);
    plan_push(OP_START, '0, '0, 12'hFFF);
    plan_push(OP_START, '0, '0, 12'd2);
    plan_link(12'd2, 12'd3);
    plan_push(OP_ADVANCE, '0, '0, '0);
    plan_link(12'd3, 12'hFF7);
    plan_push(OP_ADVANCE, '0, '0, '0);
    plan_link(12'hFF7, 12'hFF8);
    plan_push(OP_ADVANCE, '0, '0, '0);
    plan_link(12'hFF8, 12'h001);
    plan_push(OP_ADVANCE, '1, '1, '1);
    plan_link(12'h001, 12'hFFF);
    plan_push(OP_ADVANCE, '0, '0, '0);
    wait_idle();

    // Random phases, each under its own configuration, written while idle.
    // Sender gaps: 36 percent, then 63 percent, then none.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          // Zero sectors per cluster collapses every address onto the data start.
          write_reg(CFG_DATA_START, 32'h0000_0000);
          write_reg(CFG_SECTORS, 32'd0);
        end
        1: begin
          write_reg(CFG_DATA_START, 32'hFFFF_FFFF);
          write_reg(CFG_SECTORS, 32'd128);
        end
        2: begin
          write_reg(CFG_DATA_START, $urandom);
          write_reg(CFG_SECTORS, 32'd255);
        end
        3: begin
          write_reg(CFG_DATA_START, $urandom);
          write_reg(CFG_SECTORS, $urandom_range(1, 128));
        end
        4: begin
          write_reg(CFG_SECTORS, 32'd1);
          write_reg(CFG_DATA_START, $urandom);
        end
        default: begin
          write_reg(CFG_DATA_START, DATA_START_RESET);
          write_reg(CFG_SECTORS, $urandom_range(1, 128));
        end
      endcase
      idle_pct = (ph < 2) ? 36 : (ph < 4) ? 63 : 0;
      plan_random(PHASE_ITEMS);
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
